FILE: hdl/assert_macros.svh
// Assertion macros used by the core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define AST_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/fwoc_pkg.sv
// Types, constants and helpers of the ordered-check FIFO.
`timescale 1ns / 1ps
`default_nettype none
package fwoc_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int DESC_W      = (PTR_W < 1) ? 1 : PTR_W;
  localparam int DATA_W      = 32;
  localparam int FILL_W      = 7;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DESC_W-1:0] desc_t;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [DATA_W-1:0] value;
  } fwoc_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic [1:0]               status;
    logic [FILL_W-1:0]        fill_count;
    logic                     is_empty;
    logic                     in_order;
  } fwoc_out_t;

  function automatic ptr_t fwoc_next(input ptr_t i);
    fwoc_next = (i == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr_t'(i + 1'b1);
  endfunction

endpackage
`default_nettype wire

FILE: hdl/fwoc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module fwoc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hdl/fifo_with_order_check_core.sv
// Top level: ring-buffer FIFO with running order check.
// Push, clear, unused op codes and pop on empty: result valid the cycle after accept.
// One-entry pop ends in S_RD_FRONT; deeper pops read the RAM twice and end in S_RD_NEXT.
// A pop holds the input in its read states; other words run one per cycle while results drain.
// Synchronous active-low reset clears pointers, fill and descent counts and last pushed value.
// The entry RAM is not cleared; only written entries are ever read.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module fifo_with_order_check_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire fwoc_pkg::fwoc_in_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output fwoc_pkg::fwoc_out_t     out_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_FRONT,
    S_RD_NEXT
  } state_t;

  state_t              state_r, state_nxt;
  fwoc_pkg::ptr_t      front_r, front_nxt;
  fwoc_pkg::ptr_t      back_r, back_nxt;
  fwoc_pkg::cnt_t      count_r, count_nxt;
  fwoc_pkg::desc_t     desc_r, desc_nxt;
  logic signed [fwoc_pkg::DATA_W-1:0] last_r, last_nxt;
  logic signed [fwoc_pkg::DATA_W-1:0] head_r, head_nxt;
  logic                out_valid_r, out_valid_nxt;
  fwoc_pkg::fwoc_out_t res_r, res_nxt;

  logic                finish;
  logic [1:0]          status_c;
  logic signed [fwoc_pkg::DATA_W-1:0] popped_c;

  logic                ram_we;
  fwoc_pkg::ptr_t      ram_raddr;
  logic [fwoc_pkg::DATA_W-1:0] ram_rdata;

  logic in_fire, out_fire;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;
  assign ram_raddr = (state_r == S_RD_FRONT) ? fwoc_pkg::fwoc_next(front_r) : front_r;

  fwoc_ram #(
    .WIDTH (fwoc_pkg::DATA_W),
    .DEPTH (fwoc_pkg::QUEUE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (back_r),
    .wdata (in_data.value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    front_nxt = front_r;
    back_nxt  = back_r;
    count_nxt = count_r;
    desc_nxt  = desc_r;
    last_nxt  = last_r;
    head_nxt  = head_r;
    finish    = 1'b0;
    status_c  = fwoc_pkg::ST_OK;
    popped_c  = '0;
    ram_we    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_data.op)
            fwoc_pkg::OP_PUSH: begin
              finish = 1'b1;
              if (count_r >= fwoc_pkg::CNT_W'(fwoc_pkg::QUEUE_DEPTH)) begin
                status_c = fwoc_pkg::ST_PUSH_FULL;
              end else begin
                if ((count_r != '0) && ($signed(last_r) > $signed(in_data.value))) begin
                  desc_nxt = fwoc_pkg::desc_t'(desc_r + 1'b1);
                end
                ram_we    = 1'b1;
                back_nxt  = fwoc_pkg::fwoc_next(back_r);
                last_nxt  = in_data.value;
                count_nxt = fwoc_pkg::cnt_t'(count_r + 1'b1);
              end
            end
            fwoc_pkg::OP_POP: begin
              if (count_r == '0) begin
                finish   = 1'b1;
                status_c = fwoc_pkg::ST_POP_EMPTY;
              end else begin
                state_nxt = S_RD_FRONT;
              end
            end
            fwoc_pkg::OP_CLEAR: begin
              finish    = 1'b1;
              front_nxt = '0;
              back_nxt  = '0;
              count_nxt = '0;
              desc_nxt  = '0;
              last_nxt  = '0;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      S_RD_FRONT: begin
        head_nxt = ram_rdata;
        if (count_r == fwoc_pkg::CNT_W'(1)) begin
          finish    = 1'b1;
          popped_c  = ram_rdata;
          front_nxt = fwoc_pkg::fwoc_next(front_r);
          count_nxt = '0;
          desc_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_RD_NEXT;
        end
      end
      S_RD_NEXT: begin
        finish    = 1'b1;
        popped_c  = head_r;
        front_nxt = fwoc_pkg::fwoc_next(front_r);
        count_nxt = fwoc_pkg::cnt_t'(count_r - 1'b1);
        if (($signed(head_r) > $signed(ram_rdata)) && (desc_r != '0)) begin
          desc_nxt = fwoc_pkg::desc_t'(desc_r - 1'b1);
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    res_nxt              = res_r;
    res_nxt.popped_value = popped_c;
    res_nxt.status       = status_c;
    res_nxt.fill_count   = fwoc_pkg::FILL_W'(count_nxt);
    res_nxt.is_empty     = (count_nxt == '0);
    res_nxt.in_order     = (desc_nxt == '0);
    if (!finish) begin
      res_nxt = res_r;
    end

    out_valid_nxt = out_valid_r;
    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
    if (finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      back_r      <= '0;
      count_r     <= '0;
      desc_r      <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      count_r     <= count_nxt;
      desc_r      <= desc_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      res_r       <= res_nxt;
    end
  end

  `AST_CLK(a_count_bound, count_r <= fwoc_pkg::CNT_W'(fwoc_pkg::QUEUE_DEPTH), "count over depth")
  `AST_CLK(a_empty_ordered, (count_r != '0) || (desc_r == '0), "descents on empty queue")
  `AST_CLK(a_busy_blocks, (state_r == S_IDLE) || !in_ready, "word accepted during pop")
  `AST_NEXT(a_push_grows, ram_we, count_r == fwoc_pkg::cnt_t'($past(count_r) + 1'b1), "no grow")

endmodule
`default_nettype wire

FILE: tb/sv/fwoc_checker.sv
// Scoreboard for the ordered-check FIFO: shadow queue, expected words and field compare.
`timescale 1ns / 1ps
module fwoc_checker
  import fwoc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  fwoc_in_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  fwoc_out_t out_data,
  output int        mismatches,
  output int        pending,
  output int        results_checked,
  output int        full_hits,
  output int        empty_hits
);

  logic signed [DATA_W-1:0] shadow_entries [QUEUE_DEPTH];
  int                       shadow_front;
  int                       shadow_back;
  int                       shadow_count;
  int                       shadow_descents;
  logic signed [DATA_W-1:0] shadow_last;
  fwoc_out_t                expected_results [$];

  function automatic fwoc_out_t model_fifo_op(input fwoc_in_t w);
    fwoc_out_t                r;
    logic signed [DATA_W-1:0] v;
    logic signed [DATA_W-1:0] head;
    logic signed [DATA_W-1:0] after_head;
    int                       nxt;
    r = '0;
    v = w.value;
    r.status = ST_OK;
    case (w.op)
      OP_PUSH: begin
        if (shadow_count >= QUEUE_DEPTH) begin
          r.status = ST_PUSH_FULL;
        end else begin
          if (shadow_count > 0 && shadow_last > v) shadow_descents++;
          shadow_entries[shadow_back] = v;
          shadow_back = (shadow_back + 1) % QUEUE_DEPTH;
          shadow_last = v;
          shadow_count++;
        end
      end
      OP_POP: begin
        if (shadow_count == 0) begin
          r.status = ST_POP_EMPTY;
        end else begin
          nxt = (shadow_front + 1) % QUEUE_DEPTH;
          head = shadow_entries[shadow_front];
          after_head = shadow_entries[nxt];
          r.popped_value = head;
          if (shadow_count >= 2 && head > after_head && shadow_descents > 0) shadow_descents--;
          shadow_front = nxt;
          shadow_count--;
          if (shadow_count == 0) shadow_descents = 0;
        end
      end
      OP_CLEAR: begin
        shadow_front = 0;
        shadow_back = 0;
        shadow_count = 0;
        shadow_descents = 0;
        shadow_last = '0;
      end
      default: begin
      end
    endcase
    r.fill_count = FILL_W'(shadow_count);
    r.is_empty = (shadow_count == 0);
    r.in_order = (shadow_descents == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    fwoc_out_t want;
    if (!rst_n) begin
      shadow_front = 0;
      shadow_back = 0;
      shadow_count = 0;
      shadow_descents = 0;
      shadow_last = '0;
      expected_results.delete();
      mismatches <= 0;
      results_checked <= 0;
      full_hits <= 0;
      empty_hits <= 0;
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_checked <= results_checked + 1;
        if (expected_results.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("%t: result word with nothing expected: popped=%0d status=%0d fill=%0d",
                     $realtime, $signed(out_data.popped_value), out_data.status,
                     out_data.fill_count);
        end else begin
          want = expected_results.pop_front();
          if (want.status == ST_PUSH_FULL) full_hits <= full_hits + 1;
          if (want.status == ST_POP_EMPTY) empty_hits <= empty_hits + 1;
          if (out_data.popped_value !== want.popped_value || out_data.status !== want.status ||
              out_data.fill_count !== want.fill_count || out_data.is_empty !== want.is_empty ||
              out_data.in_order !== want.in_order) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("%t: mismatch exp popped=%0d st=%0d fill=%0d empty=%0b order=%0b got popped=%0d st=%0d fill=%0d empty=%0b order=%0b",
                       $realtime, $signed(want.popped_value), want.status, want.fill_count,
                       want.is_empty, want.in_order, $signed(out_data.popped_value),
                       out_data.status, out_data.fill_count, out_data.is_empty,
                       out_data.in_order);
          end
        end
      end
      if (in_valid && in_ready) expected_results.push_back(model_fifo_op(in_data));
      pending <= expected_results.size();
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// Top of the ordered-check FIFO testbench: clock, reset, word stimulus, stalls and verdict.
`timescale 1ns / 1ps
module testbench;
  import fwoc_pkg::*;

  localparam logic [1:0] OP_NONE     = 2'd3;
  localparam int         TOTAL_WORDS = 1450;
  localparam int         STALL_LIMIT = 2000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  fwoc_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  fwoc_out_t out_data;

  int mismatches;
  int pending;
  int results_checked;
  int full_hits;
  int empty_hits;

  int send_idle_pct;
  int recv_idle_pct;
  int words_sent;
  int push_words;
  int pop_words;
  int clear_words;
  int noop_words;
  int quiet_cycles;
  logic signed [DATA_W-1:0] ramp_value;

  fifo_with_order_check_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  fwoc_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked),
    .full_hits       (full_hits),
    .empty_hits      (empty_hits)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_value(input int style);
    logic signed [DATA_W-1:0] v;
    case (style)
      0: begin
        ramp_value = ramp_value + $urandom_range(0, 3);
        v = ramp_value;
      end
      1: v = $signed($urandom_range(0, 7)) - 4;
      2: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh7fffffff;
          1: v = 32'sh80000000;
          2: v = '0;
          default: v = -1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_op(input logic [1:0] op, input logic signed [DATA_W-1:0] v);
    fwoc_in_t w;
    if (words_sent < TOTAL_WORDS / 3) begin
      send_idle_pct = 38;
      recv_idle_pct = 65;
    end else if (words_sent < 2 * TOTAL_WORDS / 3) begin
      send_idle_pct = 65;
      recv_idle_pct = 38;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    w.op = op;
    w.value = v;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    case (op)
      OP_PUSH:  push_words++;
      OP_POP:   pop_words++;
      OP_CLEAR: clear_words++;
      default:  noop_words++;
    endcase
  endtask

  initial begin
    int seg;
    int style;
    int pick;
    in_valid <= 1'b0;
    in_data <= '0;
    out_ready <= 1'b0;
    rst_n <= 1'b0;
    send_idle_pct = 38;
    recv_idle_pct = 65;
    words_sent = 0;
    push_words = 0;
    pop_words = 0;
    clear_words = 0;
    noop_words = 0;
    ramp_value = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_op(OP_POP, $urandom);
    send_op(OP_PUSH, 32'sh7fffffff);
    send_op(OP_PUSH, 32'sh80000000);
    send_op(OP_PUSH, 0);
    send_op(OP_PUSH, -1);
    send_op(OP_PUSH, -1);
    send_op(OP_NONE, 32'sh80000000);
    repeat (5) send_op(OP_POP, $urandom);
    send_op(OP_POP, 32'sh7fffffff);
    send_op(OP_PUSH, 5);
    send_op(OP_PUSH, 5);
    send_op(OP_PUSH, 4);
    send_op(OP_CLEAR, -1);
    send_op(OP_POP, 0);
    send_op(OP_PUSH, 32'sh7fffffff);
    send_op(OP_NONE, 32'sh7fffffff);
    send_op(OP_CLEAR, $urandom);
    send_op(OP_PUSH, 32'sh80000000);
    send_op(OP_PUSH, 32'sh7fffffff);

    while (words_sent < TOTAL_WORDS) begin
      seg = $urandom_range(0, 9);
      style = $urandom_range(0, 3);
      ramp_value = $urandom;
      if (seg < 2) begin
        repeat (QUEUE_DEPTH + $urandom_range(1, 3)) send_op(OP_PUSH, pick_value(style));
      end else if (seg < 4) begin
        repeat (QUEUE_DEPTH + $urandom_range(1, 3)) send_op(OP_POP, $urandom);
      end else begin
        repeat ($urandom_range(8, 40)) begin
          pick = $urandom_range(0, 99);
          if (pick < 48) send_op(OP_PUSH, pick_value(style));
          else if (pick < 88) send_op(OP_POP, $urandom);
          else if (pick < 94) send_op(OP_CLEAR, $urandom);
          else send_op(OP_NONE, $urandom);
        end
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d words: %0d push, %0d pop, %0d clear, %0d unused op", words_sent,
             push_words, pop_words, clear_words, noop_words);
    $display("Checked %0d results, %0d push on full, %0d pop on empty, %0d mismatches",
             results_checked, full_hits, empty_hits, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/fwoc_pkg.sv
hdl/fwoc_ram.sv
hdl/fifo_with_order_check_core.sv
tb/sv/fwoc_checker.sv
tb/sv/testbench.sv
